// ----- hdl/actuator_position_controller_top_macros.svh -----
// ----------------------------------------------------------------------------
// Actuator position controller assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_POSITION_CONTROLLER_TOP_MACROS_SVH
`define ACTUATOR_POSITION_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and off while reset is asserted.
`define APC_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apc: same-cycle check failed");

// Next-cycle implication, sampled on clk and off while reset is asserted.
`define APC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apc: next-cycle check failed");

`endif

// ----- hdl/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// Actuator position controller package
// Shared widths, register indexes, reset values, codes and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

    // Field widths fixed by the interface.
    localparam int FB_W       = 12;
    localparam int LEN_W      = 11;
    localparam int TOL_W      = 8;
    localparam int TRIES_W    = 3;
    localparam int CPM_W      = 16;
    localparam int MPC_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: a 12-bit operand by a 16-bit operand.
    localparam int MUL_A_W = 12;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // Rounding offset and shift for the Q-format scaling (+2048 >> 12).
    localparam int RND_SHIFT = 12;
    localparam int SCALED_W  = PROD_W + 1 - RND_SHIFT;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPM_Q8     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MPC_Q16    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 3'd5;

    // Configuration reset values.
    localparam logic [FB_W-1:0]    RST_MIN_CODE   = 12'd819;
    localparam logic [CPM_W-1:0]   RST_CPM_Q8     = 16'd6190;
    localparam logic [MPC_W-1:0]   RST_MPC_Q16    = 16'd2710;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE  = 8'd8;
    localparam logic [TRIES_W-1:0] RST_MAX_TRIES  = 3'd3;
    localparam logic [LEN_W-1:0]   RST_MAX_LENGTH = 11'd1648;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_REACHED = 2'd1,
        STATUS_GAVE_UP = 2'd2
    } status_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [FB_W-1:0]    min_code;
        logic [CPM_W-1:0]   codes_per_mm_q8;
        logic [MPC_W-1:0]   mm_per_code_q16;
        logic [TOL_W-1:0]   tolerance_code;
        logic [TRIES_W-1:0] max_tries;
        logic [LEN_W-1:0]   max_length;
    } cfg_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic latch;       // capture the accepted item
        logic mul_go;      // register one product
        logic mul_len;     // product operands: 1 length scaling, 0 target scaling
        logic tgt_load;    // load the target code from the product
        logic win_write;   // write the held sample into the window
        logic fill_clear;  // restart window filling
        logic fill_inc;    // advance the fill pointer
        logic mode_start;  // clear the mode search
        logic mode_step;   // score one window entry
        logic fb_load;     // take the mode as filtered feedback
        logic len_load;    // load the length from the product
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic window_last;  // this sample completes the window
        logic mode_last;    // the mode search scores its last entry
        logic out_band;     // 2*|target-mode| > 3*tolerance
        logic ext_go;       // target above mode by more than tolerance
        logic ret_go;       // mode above target by more than tolerance
        logic dir_extend;   // target above max(mode, min_code)
    } dp_stat_t;

    // Control part of one result item.
    typedef struct packed {
        logic    motor_enable;
        logic    direction;
        logic    feedback_valid;
        logic    busy;
        status_t status;
    } ctl_res_t;

endpackage

`default_nettype wire

// ----- hdl/apc_datapath.sv -----
// ----------------------------------------------------------------------------
// Actuator position controller datapath
// Sample window, mode search, shared scaling multiplier and error compares.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_datapath #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  apc_pkg::cfg_t                  cfg,
    input  apc_pkg::dp_cmd_t               cmd,
    output apc_pkg::dp_stat_t              stat,
    input  logic [apc_pkg::LEN_W-1:0]      target_length,
    input  logic [SAMPLE_BITS-1:0]         sample,
    output logic [apc_pkg::FB_W-1:0]       feedback,
    output logic [apc_pkg::LEN_W-1:0]      length
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam int FB_W  = apc_pkg::FB_W;
    localparam int LEN_W = apc_pkg::LEN_W;

    // Held item.
    logic [LEN_W-1:0]        len_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;

    // Window and mode search.
    logic [SAMPLE_BITS-1:0]  win_reg [WINDOW];
    logic [IDX_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        best_cnt_reg, best_cnt_next;
    logic [SAMPLE_BITS-1:0]  best_val_reg, best_val_next;
    logic [SAMPLE_BITS-1:0]  cand;
    logic [CNT_W-1:0]        cand_cnt;

    // Scaling and results.
    logic [apc_pkg::PROD_W-1:0]    prod_reg;
    logic [apc_pkg::MUL_A_W-1:0]   mul_a;
    logic [apc_pkg::MUL_B_W-1:0]   mul_b;
    logic [apc_pkg::PROD_W:0]      rounded;
    logic [apc_pkg::SCALED_W-1:0]  scaled;
    logic [apc_pkg::SCALED_W:0]    tgt_sum;
    logic [FB_W-1:0]               tgt_reg, filt_reg, mode_fb, above_min;
    logic [LEN_W-1:0]              length_reg, len_clamp;
    logic [SAMPLE_BITS+FB_W-1:0]   mode_ext;

    // Error compares.
    logic             t_gt_fb, fb_gt_t;
    logic [FB_W-1:0]  err, floor_fb;
    logic [FB_W:0]    err_x2;
    logic [apc_pkg::TOL_W+1:0] tol_x3;

    // Item capture with the requested length clamped to max_length.
    assign len_clamp = (target_length > cfg.max_length) ? cfg.max_length : target_length;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            len_reg    <= len_clamp;
            sample_reg <= sample;
        end
    end

    // Window store, written at the fill pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.win_write)
        begin
            win_reg[fill_reg] <= sample_reg;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.fill_clear)
        begin
            fill_next = '0;
        end
        else if (cmd.fill_inc)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign stat.window_last = (fill_reg == LAST_IDX);

    // Mode search: one candidate entry scored against the whole window per cycle.
    // A zero entry scores zero, and a strictly higher score is needed to win.
    always_comb
    begin
        cand     = win_reg[idx_reg];
        cand_cnt = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            cand_cnt = cand_cnt + CNT_W'(win_reg[k] == cand);
        end
        if (cand == '0)
        begin
            cand_cnt = '0;
        end
    end

    always_comb
    begin
        idx_next      = idx_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        if (cmd.mode_start)
        begin
            idx_next      = '0;
            best_cnt_next = '0;
            best_val_next = '0;
        end
        else if (cmd.mode_step)
        begin
            idx_next = idx_reg + 1'b1;
            if (cand_cnt > best_cnt_reg)
            begin
                best_cnt_next = cand_cnt;
                best_val_next = cand;
            end
        end
    end

    assign stat.mode_last = (idx_reg == LAST_IDX);

    // The mode as a feedback code: zero-extended, then cut to the feedback width.
    assign mode_ext = {{FB_W{1'b0}}, best_val_reg};
    assign mode_fb  = mode_ext[FB_W-1:0];

    // Compares of the new feedback against the target.
    assign t_gt_fb  = (tgt_reg > mode_fb);
    assign fb_gt_t  = (mode_fb > tgt_reg);
    assign err      = t_gt_fb ? (tgt_reg - mode_fb) : (mode_fb - tgt_reg);
    assign err_x2   = {err, 1'b0};
    assign tol_x3   = {1'b0, cfg.tolerance_code, 1'b0} + {2'b00, cfg.tolerance_code};
    assign floor_fb = (mode_fb > cfg.min_code) ? mode_fb : cfg.min_code;

    assign stat.out_band   = (err_x2 > (FB_W+1)'(tol_x3));
    assign stat.ext_go     = t_gt_fb && (err > FB_W'(cfg.tolerance_code));
    assign stat.ret_go     = fb_gt_t && (err > FB_W'(cfg.tolerance_code));
    assign stat.dir_extend = (tgt_reg > floor_fb);

    // Shared multiplier: length scaling or target scaling.
    assign above_min = (filt_reg > cfg.min_code) ? (filt_reg - cfg.min_code) : '0;
    assign mul_a = cmd.mul_len ? above_min : apc_pkg::MUL_A_W'(len_reg);
    assign mul_b = cmd.mul_len ? cfg.mm_per_code_q16 : cfg.codes_per_mm_q8;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Round to nearest after the 12-bit scale-down.
    assign rounded = {1'b0, prod_reg} + (apc_pkg::PROD_W+1)'(2048);
    assign scaled  = rounded[apc_pkg::PROD_W:apc_pkg::RND_SHIFT];
    assign tgt_sum = {1'b0, scaled} + (apc_pkg::SCALED_W+1)'(cfg.min_code);

    // Control and result state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            idx_reg      <= '0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
            tgt_reg      <= '0;
            filt_reg     <= '0;
            length_reg   <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            best_cnt_reg <= best_cnt_next;
            best_val_reg <= best_val_next;
            if (cmd.tgt_load)
            begin
                tgt_reg <= (tgt_sum > (apc_pkg::SCALED_W+1)'(4095)) ? '1 : tgt_sum[FB_W-1:0];
            end
            if (cmd.fb_load)
            begin
                filt_reg <= mode_fb;
            end
            if (cmd.len_load)
            begin
                length_reg <= (scaled > apc_pkg::SCALED_W'(2047)) ? '1 : scaled[LEN_W-1:0];
            end
        end
    end

    assign feedback = filt_reg;
    assign length   = length_reg;

endmodule

`default_nettype wire

// ----- hdl/apc_controller.sv -----
// ----------------------------------------------------------------------------
// Actuator position controller sequencer
// Steps each item through the datapath and runs the positioning phases.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_cmd,
    output logic                          item_stall,
    input  logic [apc_pkg::TRIES_W-1:0]   max_tries,
    input  logic                          out_free,
    output logic                          out_load,
    output apc_pkg::ctl_res_t             res,
    output apc_pkg::dp_cmd_t              cmd,
    input  apc_pkg::dp_stat_t             stat
);

    // Item sequencer states.
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SET_MUL  = 9'b000000010,
        S_SET_TGT  = 9'b000000100,
        S_SAMPLE   = 9'b000001000,
        S_MODE     = 9'b000010000,
        S_DECIDE   = 9'b000100000,
        S_LEN_MUL  = 9'b001000000,
        S_LEN_SAT  = 9'b010000000,
        S_DONE     = 9'b100000000
    } seq_t;

    // Positioning phases.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_CHECK   = 4'b0010,
        PH_EXTEND  = 4'b0100,
        PH_RETRACT = 4'b1000
    } phase_t;

    seq_t                         state_reg, state_next;
    phase_t                       phase_reg, phase_next;
    logic [apc_pkg::TRIES_W-1:0]  tries_reg, tries_next;
    apc_pkg::status_t             status_reg, status_next;
    logic                         fbv_reg, fbv_next;
    logic                         accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // Sequencer and phase logic.
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        tries_next  = tries_reg;
        status_next = status_reg;
        fbv_next    = fbv_reg;
        cmd         = '0;
        out_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch   = 1'b1;
                    status_next = apc_pkg::STATUS_NONE;
                    fbv_next    = 1'b0;
                    state_next  = item_cmd ? S_SAMPLE : S_SET_MUL;
                end
            end
            S_SET_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_SET_TGT;
            end
            S_SET_TGT:
            begin
                // A set command restarts positioning from a fresh window.
                cmd.tgt_load   = 1'b1;
                cmd.fill_clear = 1'b1;
                tries_next     = '0;
                phase_next     = PH_CHECK;
                state_next     = S_LEN_MUL;
            end
            S_SAMPLE:
            begin
                cmd.win_write = 1'b1;
                if (stat.window_last)
                begin
                    cmd.fill_clear = 1'b1;
                    cmd.mode_start = 1'b1;
                    state_next     = S_MODE;
                end
                else
                begin
                    cmd.fill_inc = 1'b1;
                    state_next   = S_LEN_MUL;
                end
            end
            S_MODE:
            begin
                cmd.mode_step = 1'b1;
                if (stat.mode_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.fb_load = 1'b1;
                fbv_next    = 1'b1;
                case (phase_reg)
                    PH_CHECK:
                    begin
                        if (stat.out_band && (tries_reg < max_tries))
                        begin
                            phase_next = stat.dir_extend ? PH_EXTEND : PH_RETRACT;
                            tries_next = tries_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_IDLE;
                            status_next = stat.out_band ? apc_pkg::STATUS_GAVE_UP
                                                        : apc_pkg::STATUS_REACHED;
                        end
                    end
                    PH_EXTEND:
                    begin
                        if (!stat.ext_go)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_RETRACT:
                    begin
                        if (!stat.ret_go)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                state_next = S_LEN_MUL;
            end
            S_LEN_MUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_len = 1'b1;
                state_next  = S_LEN_SAT;
            end
            S_LEN_SAT:
            begin
                cmd.len_load = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_IDLE;
            tries_reg  <= '0;
            status_reg <= apc_pkg::STATUS_NONE;
            fbv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            tries_reg  <= tries_next;
            status_reg <= status_next;
            fbv_reg    <= fbv_next;
        end
    end

    // Control fields of the result item.
    assign res.motor_enable   = (phase_reg == PH_EXTEND) || (phase_reg == PH_RETRACT);
    assign res.direction      = (phase_reg == PH_EXTEND);
    assign res.feedback_valid = fbv_reg;
    assign res.busy           = (phase_reg != PH_IDLE);
    assign res.status         = status_reg;

endmodule

`default_nettype wire

// ----- hdl/actuator_position_controller_top.sv -----
// ----------------------------------------------------------------------------
// Actuator position controller top level
// Sequence: a set command scales the target and then the length; a sample that
// leaves the window open scales the length only; a sample that completes it
// first runs the mode search and the phase decision. One item is worked at a
// time; the mode search scores one window entry per cycle.
// Reset: asynchronous, active low; configuration returns to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "actuator_position_controller_top_macros.svh"

module actuator_position_controller_top #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [apc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Item channel.
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               cmd,
    input  logic [apc_pkg::LEN_W-1:0]          target_length,
    input  logic [SAMPLE_BITS-1:0]             sample,
    // Result channel.
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               motor_enable,
    output logic                               direction,
    output logic                               feedback_valid,
    output logic [apc_pkg::FB_W-1:0]           feedback,
    output logic [apc_pkg::LEN_W-1:0]          length,
    output logic                               busy_res,
    output logic [1:0]                         status
);

    apc_pkg::cfg_t       cfg_reg;
    apc_pkg::dp_cmd_t    dp_cmd;
    apc_pkg::dp_stat_t   dp_stat;
    apc_pkg::ctl_res_t   ctl_res;
    logic [apc_pkg::FB_W-1:0]  dp_feedback;
    logic [apc_pkg::LEN_W-1:0] dp_length;
    logic                out_free, out_load;
    logic                result_valid_reg, result_valid_next;
    apc_pkg::ctl_res_t   res_ctl_reg;
    logic [apc_pkg::FB_W-1:0]  res_fb_reg;
    logic [apc_pkg::LEN_W-1:0] res_len_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_code        <= apc_pkg::RST_MIN_CODE;
            cfg_reg.codes_per_mm_q8 <= apc_pkg::RST_CPM_Q8;
            cfg_reg.mm_per_code_q16 <= apc_pkg::RST_MPC_Q16;
            cfg_reg.tolerance_code  <= apc_pkg::RST_TOLERANCE;
            cfg_reg.max_tries       <= apc_pkg::RST_MAX_TRIES;
            cfg_reg.max_length      <= apc_pkg::RST_MAX_LENGTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                apc_pkg::REG_MIN_CODE:   cfg_reg.min_code <= cfg_data[apc_pkg::FB_W-1:0];
                apc_pkg::REG_CPM_Q8:     cfg_reg.codes_per_mm_q8 <= cfg_data;
                apc_pkg::REG_MPC_Q16:    cfg_reg.mm_per_code_q16 <= cfg_data;
                apc_pkg::REG_TOLERANCE:  cfg_reg.tolerance_code <= cfg_data[apc_pkg::TOL_W-1:0];
                apc_pkg::REG_MAX_TRIES:  cfg_reg.max_tries <= cfg_data[apc_pkg::TRIES_W-1:0];
                apc_pkg::REG_MAX_LENGTH: cfg_reg.max_length <= cfg_data[apc_pkg::LEN_W-1:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Sequencer.
    apc_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (cmd),
        .item_stall (item_stall),
        .max_tries  (cfg_reg.max_tries),
        .out_free   (out_free),
        .out_load   (out_load),
        .res        (ctl_res),
        .cmd        (dp_cmd),
        .stat       (dp_stat)
    );

    // Datapath.
    apc_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .target_length (target_length),
        .sample        (sample),
        .feedback      (dp_feedback),
        .length        (dp_length)
    );

    // Result register: holds a finished item while the next one is taken in.
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_ctl_reg <= ctl_res;
            res_fb_reg  <= dp_feedback;
            res_len_reg <= dp_length;
        end
    end

    assign result_valid   = result_valid_reg;
    assign motor_enable   = res_ctl_reg.motor_enable;
    assign direction      = res_ctl_reg.direction;
    assign feedback_valid = res_ctl_reg.feedback_valid;
    assign feedback       = res_fb_reg;
    assign length         = res_len_reg;
    assign busy_res       = res_ctl_reg.busy;
    assign status         = res_ctl_reg.status;

    // Driving only happens while a command is in progress.
    `APC_ASSERT_IMPLY(a_drive_busy, result_valid && motor_enable, busy_res)
    // Extend is only reported while the motor is on.
    `APC_ASSERT_IMPLY(a_dir_drive, result_valid && direction, motor_enable)
    // A report ends the command and comes only with a new window.
    `APC_ASSERT_IMPLY(a_report_idle, result_valid && (status != apc_pkg::STATUS_NONE), !busy_res && feedback_valid)
    // One item is worked at a time.
    `APC_ASSERT_NEXT(a_one_item, item_valid && !item_stall, item_stall)

endmodule

`default_nettype wire

// ----- dv/tb_actuator_position_controller_top.sv -----
// ----------------------------------------------------------------------------
// Actuator position controller testbench
// Drives set commands and feedback samples through the item channel and
// checks every result against a cycle-free predictor of the controller. The
// run walks through several register settings and idle patterns on both
// channels. Stimulus is mostly whole positioning episodes: a set command
// followed by full sample windows whose mode sits near, at the edge of, or
// far from the target. Noise items and episodes cut short by a new set
// command fill the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_actuator_position_controller_top;

    import apc_pkg::*;

    localparam int WINDOW          = 10;
    localparam int SAMPLE_BITS     = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;

    // Command codes on the cmd field.
    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Positioning phases of the controller.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CHECK,
        CTL_EXTEND,
        CTL_RETRACT
    } ctl_phase_t;

    typedef struct packed {
        logic                   cmd;
        logic [LEN_W-1:0]       len;
        logic [SAMPLE_BITS-1:0] smp;
    } ctl_item_t;

    typedef struct packed {
        logic             motor_enable;
        logic             direction;
        logic             feedback_valid;
        logic [FB_W-1:0]  feedback;
        logic [LEN_W-1:0] length;
        logic             busy;
        status_t          status;
    } ctl_result_t;

    // Clock, reset and block ports.
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                    item_valid    = 1'b0;
    logic                    item_stall;
    logic                    cmd           = CMD_SET;
    logic [LEN_W-1:0]        target_length = '0;
    logic [SAMPLE_BITS-1:0]  sample        = '0;
    logic                    result_valid;
    logic                    result_stall  = 1'b0;
    logic                    motor_enable;
    logic                    direction;
    logic                    feedback_valid;
    logic [FB_W-1:0]         feedback;
    logic [LEN_W-1:0]        length;
    logic                    busy_res;
    logic [1:0]              status;

    // Predictor state and its copy of the register file.
    cfg_t ctl_cfg = '{
        min_code:        RST_MIN_CODE,
        codes_per_mm_q8: RST_CPM_Q8,
        mm_per_code_q16: RST_MPC_Q16,
        tolerance_code:  RST_TOLERANCE,
        max_tries:       RST_MAX_TRIES,
        max_length:      RST_MAX_LENGTH
    };
    logic [FB_W-1:0]    sample_win [WINDOW];
    int                 fill_cnt   = 0;
    ctl_phase_t         ctl_phase  = CTL_IDLE;
    logic [FB_W-1:0]    target_q   = '0;
    logic [TRIES_W-1:0] tries_cnt  = '0;
    logic [FB_W-1:0]    filt_fb    = '0;

    // Stimulus and checking bookkeeping.
    ctl_item_t   pending_items [$];
    ctl_result_t expected_results [$];
    ctl_item_t   held_item;
    bit          item_taken    = 1'b0;
    int          outstanding   = 0;
    int          queued_total  = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    actuator_position_controller_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .cmd            (cmd),
        .target_length  (target_length),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .motor_enable   (motor_enable),
        .direction      (direction),
        .feedback_valid (feedback_valid),
        .feedback       (feedback),
        .length         (length),
        .busy_res       (busy_res),
        .status         (status)
    );

    always #5 clk = ~clk;

    // Target ADC code for a requested length under the current registers.
    function automatic logic [FB_W-1:0] code_of_length(logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] clamped;
        logic [31:0]      code;
        clamped = (len > ctl_cfg.max_length) ? ctl_cfg.max_length : len;
        code = ctl_cfg.min_code + ((clamped * ctl_cfg.codes_per_mm_q8 + 32'd2048) >> 12);
        return (code > 32'd4095) ? 12'hFFF : code[FB_W-1:0];
    endfunction

    // Advance the controller by one item and return the result it causes.
    function automatic ctl_result_t advance_controller(ctl_item_t it);
        ctl_result_t res;
        int          best_idx;
        int          best_cnt;
        int          cnt;
        logic [FB_W-1:0] fb;
        logic [FB_W-1:0] err;
        logic [FB_W-1:0] floor_fb;
        logic        out_band;
        logic [31:0] scaled;
        res = '0;
        res.status = STATUS_NONE;
        if (it.cmd == CMD_SET)
        begin
            target_q  = code_of_length(it.len);
            tries_cnt = '0;
            fill_cnt  = 0;
            ctl_phase = CTL_CHECK;
        end
        else
        begin
            sample_win[fill_cnt] = it.smp;
            fill_cnt++;
            if (fill_cnt == WINDOW)
            begin
                fill_cnt = 0;
                // Mode of the window: zero entries never win, ties go to the earliest.
                best_idx = 0;
                best_cnt = 0;
                for (int i = 0; i < WINDOW; i++)
                begin
                    cnt = 0;
                    if (sample_win[i] != 0)
                    begin
                        for (int k = 0; k < WINDOW; k++)
                        begin
                            if (sample_win[k] == sample_win[i])
                                cnt++;
                        end
                    end
                    if (cnt > best_cnt)
                    begin
                        best_cnt = cnt;
                        best_idx = i;
                    end
                end
                fb = sample_win[best_idx];
                filt_fb = fb;
                res.feedback_valid = 1'b1;
                err = (target_q > fb) ? target_q - fb : fb - target_q;
                case (ctl_phase)
                    CTL_CHECK:
                    begin
                        out_band = (2 * err) > (3 * ctl_cfg.tolerance_code);
                        if (out_band && tries_cnt < ctl_cfg.max_tries)
                        begin
                            floor_fb  = (fb > ctl_cfg.min_code) ? fb : ctl_cfg.min_code;
                            ctl_phase = (target_q > floor_fb) ? CTL_EXTEND : CTL_RETRACT;
                            tries_cnt = tries_cnt + 1'b1;
                        end
                        else
                        begin
                            ctl_phase  = CTL_IDLE;
                            res.status = out_band ? STATUS_GAVE_UP : STATUS_REACHED;
                        end
                    end
                    CTL_EXTEND:
                    begin
                        if (!(target_q > fb && target_q - fb > ctl_cfg.tolerance_code))
                            ctl_phase = CTL_CHECK;
                    end
                    CTL_RETRACT:
                    begin
                        if (!(fb > target_q && fb - target_q > ctl_cfg.tolerance_code))
                            ctl_phase = CTL_CHECK;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        res.motor_enable = (ctl_phase == CTL_EXTEND) || (ctl_phase == CTL_RETRACT);
        res.direction    = (ctl_phase == CTL_EXTEND);
        res.feedback     = filt_fb;
        res.busy         = (ctl_phase != CTL_IDLE);
        // Length from the filtered code, clamped at zero and saturated.
        if (filt_fb <= ctl_cfg.min_code)
            res.length = '0;
        else
        begin
            scaled = ((filt_fb - ctl_cfg.min_code) * ctl_cfg.mm_per_code_q16 + 32'd2048) >> 12;
            res.length = (scaled > 32'd2047) ? 11'h7FF : scaled[LEN_W-1:0];
        end
        return res;
    endfunction

    task automatic push_item(logic c, logic [LEN_W-1:0] l, logic [SAMPLE_BITS-1:0] s);
        ctl_item_t it;
        it.cmd = c;
        it.len = l;
        it.smp = s;
        pending_items.push_back(it);
        outstanding++;
        queued_total++;
    endtask

    // Queue the first n samples of one window built around a mode level.
    task automatic queue_window(int level, int n);
        logic [FB_W-1:0] vals [WINDOW];
        logic [FB_W-1:0] other;
        logic [FB_W-1:0] tmp;
        int style;
        int j;
        style = $urandom_range(0, 9);
        other = FB_W'($urandom_range(0, 4095));
        for (int i = 0; i < WINDOW; i++)
        begin
            if (style <= 5)
            begin
                if ($urandom_range(0, 99) < 70)
                    vals[i] = FB_W'(level);
                else if ($urandom_range(0, 4) == 0)
                    vals[i] = '0;
                else
                    vals[i] = FB_W'($urandom_range(0, 4095));
            end
            else if (style == 6)
                vals[i] = (i < WINDOW / 2) ? FB_W'(level) : other;
            else if (style == 7)
                vals[i] = '0;
            else if (style == 8)
                vals[i] = (i < 3) ? FB_W'(level) : '0;
            else
                vals[i] = FB_W'($urandom_range(0, 4095));
        end
        for (int i = WINDOW - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            push_item(CMD_SAMPLE, LEN_W'($urandom_range(0, 2047)), vals[i]);
    endtask

    // One positioning episode, a cut-short episode, or a burst of noise.
    task automatic queue_episode();
        logic [LEN_W-1:0] len;
        int kind;
        int nwin;
        int tgt;
        int tol;
        int off;
        int level;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 12))
                push_item(1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 2047)),
                          SAMPLE_BITS'($urandom_range(0, 4095)));
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: len = '0;
                1: len = 11'h7FF;
                2: len = ctl_cfg.max_length;
                3: len = ctl_cfg.max_length + 1'b1;
                default: len = LEN_W'($urandom_range(0, 2047));
            endcase
            push_item(CMD_SET, len, SAMPLE_BITS'($urandom_range(0, 4095)));
            tgt  = code_of_length(len);
            tol  = ctl_cfg.tolerance_code;
            nwin = $urandom_range(1, 6);
            for (int w = 0; w < nwin; w++)
            begin
                // Place the window mode relative to the target and the stop bands.
                case ($urandom_range(0, 5))
                    0: off = 0;
                    1: off = $urandom_range(0, tol);
                    2: off = int'($urandom_range(0, 2)) - 1 + (3 * tol) / 2;
                    3: off = tol + int'($urandom_range(0, tol / 2 + 1));
                    4: off = $urandom_range(0, 4095);
                    default: off = 4096;
                endcase
                level = $urandom_range(0, 1) ? tgt + off : tgt - off;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                // Some episodes are cut short by the next set command.
                if (kind < 20 && w == nwin - 1)
                    queue_window(level, $urandom_range(1, WINDOW - 1));
                else
                    queue_window(level, WINDOW);
            end
        end
    endtask

    // Register write at the falling edge; the predictor copy follows.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_MIN_CODE:   ctl_cfg.min_code        = data[FB_W-1:0];
            REG_CPM_Q8:     ctl_cfg.codes_per_mm_q8 = data[CPM_W-1:0];
            REG_MPC_Q16:    ctl_cfg.mm_per_code_q16 = data[MPC_W-1:0];
            REG_TOLERANCE:  ctl_cfg.tolerance_code  = data[TOL_W-1:0];
            REG_MAX_TRIES:  ctl_cfg.max_tries       = data[TRIES_W-1:0];
            REG_MAX_LENGTH: ctl_cfg.max_length      = data[LEN_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Item acceptance: predict the result of the item just taken.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            expected_results.push_back(advance_controller(held_item));
            item_taken = 1'b1;
        end
    end

    // Item driver: hold a stalled item, otherwise maybe load the next one.
    always @(negedge clk)
    begin
        logic hold;
        hold = item_valid && !item_taken;
        item_taken = 1'b0;
        if (!hold && rst_n && pending_items.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct)
        begin
            held_item = pending_items.pop_front();
            cmd           <= held_item.cmd;
            target_length <= held_item.len;
            sample        <= held_item.smp;
            hold = 1'b1;
        end
        item_valid <= hold;
    end

    // Result backpressure.
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        ctl_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual feedback %0d status %0d",
                         $time, feedback, status);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("motor_enable", want.motor_enable, motor_enable);
                check_field("direction", want.direction, direction);
                check_field("feedback_valid", want.feedback_valid, feedback_valid);
                check_field("feedback", want.feedback, feedback);
                check_field("length", want.length, length);
                check_field("busy_res", want.busy, busy_res);
                check_field("status", want.status, status);
                outstanding--;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Test sequence: reset, then one phase per register setting.
    initial
    begin
        logic [CFG_DATA_W-1:0] reg_val [8];
        logic [FB_W-1:0]       tie_window [WINDOW];
        int                    phase_end;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                // The sender stays paused here until every result is back.
                wait_drained();
                if (p == 1)
                begin
                    reg_val[REG_MIN_CODE]   = 16'h0000;
                    reg_val[REG_CPM_Q8]     = 16'hFFFF;
                    reg_val[REG_MPC_Q16]    = 16'hFFFF;
                    reg_val[REG_TOLERANCE]  = 16'h0000;
                    reg_val[REG_MAX_TRIES]  = 16'h0007;
                    reg_val[REG_MAX_LENGTH] = 16'h07FF;
                end
                else if (p == 2)
                begin
                    reg_val[REG_MIN_CODE]   = 16'h0FFF;
                    reg_val[REG_CPM_Q8]     = 16'h0000;
                    reg_val[REG_MPC_Q16]    = 16'h0000;
                    reg_val[REG_TOLERANCE]  = 16'h00FF;
                    reg_val[REG_MAX_TRIES]  = 16'h0000;
                    reg_val[REG_MAX_LENGTH] = 16'h0000;
                end
                else if (p == 4)
                begin
                    reg_val[REG_MIN_CODE]   = CFG_DATA_W'(RST_MIN_CODE);
                    reg_val[REG_CPM_Q8]     = RST_CPM_Q8;
                    reg_val[REG_MPC_Q16]    = RST_MPC_Q16;
                    reg_val[REG_TOLERANCE]  = CFG_DATA_W'($urandom_range(1, 20));
                    reg_val[REG_MAX_TRIES]  = CFG_DATA_W'($urandom_range(1, 2));
                    reg_val[REG_MAX_LENGTH] = CFG_DATA_W'(RST_MAX_LENGTH);
                end
                else
                begin
                    // Random settings; unused upper data bits are random too.
                    reg_val[REG_MIN_CODE]   = CFG_DATA_W'($urandom);
                    reg_val[REG_CPM_Q8]     = CFG_DATA_W'($urandom);
                    reg_val[REG_MPC_Q16]    = CFG_DATA_W'($urandom);
                    reg_val[REG_TOLERANCE]  =
                        CFG_DATA_W'(($urandom & 32'hFF00) | $urandom_range(0, 40));
                    reg_val[REG_MAX_TRIES]  = CFG_DATA_W'($urandom);
                    reg_val[REG_MAX_LENGTH] = CFG_DATA_W'($urandom);
                end
                write_reg(REG_MIN_CODE, reg_val[REG_MIN_CODE]);
                write_reg(REG_CPM_Q8, reg_val[REG_CPM_Q8]);
                write_reg(REG_MPC_Q16, reg_val[REG_MPC_Q16]);
                write_reg(REG_TOLERANCE, reg_val[REG_TOLERANCE]);
                write_reg(REG_MAX_TRIES, reg_val[REG_MAX_TRIES]);
                write_reg(REG_MAX_LENGTH, reg_val[REG_MAX_LENGTH]);
            end

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase

            if (p == 0)
            begin
                // Length extremes, with the longest clamped to the maximum.
                push_item(CMD_SET, 11'd0, 12'hFFF);
                push_item(CMD_SET, 11'h7FF, 12'h000);
                // Zeros never win, and a tie goes to the earliest value: full
                // scale wins, the actuator retracts and the length saturates.
                tie_window = '{12'd0, 12'hFFF, 12'd0, 12'd1, 12'd0,
                               12'hFFF, 12'd0, 12'd1, 12'd0, 12'd0};
                for (int i = 0; i < WINDOW; i++)
                    push_item(CMD_SAMPLE, (i % 2) ? 11'h7FF : 11'd0, tie_window[i]);
                // An all-zero window filters to zero and stops the retract.
                for (int i = 0; i < WINDOW; i++)
                    push_item(CMD_SAMPLE, (i % 2) ? 11'd0 : 11'h7FF, 12'd0);
            end

            phase_end = queued_total + ITEMS_PER_PHASE;
            while (queued_total < phase_end)
                queue_episode();
        end

        wait_drained();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/apc_pkg.sv
hdl/apc_datapath.sv
hdl/apc_controller.sv
hdl/actuator_position_controller_top.sv
dv/tb_actuator_position_controller_top.sv
